// ===== design/cpsl_pkg.sv =====
// Shared types and constants for the common prefix and suffix length block.
package cpsl_pkg;

  localparam int CH_W  = 8;
  localparam int LEN_W = 11;
  localparam logic [LEN_W-1:0] FIELD_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take an input beat, write the store, start the prefix read
    logic chk;        // compare the character against the first string
    logic end_first;  // close the first string of a set
    logic end_other;  // close a later string and start the suffix walk
    logic walk_rd;    // read both stores at the current walk offset
    logic walk_step;  // characters matched, advance the walk offset
    logic fin;        // commit the suffix length and rewind the string position
    logic emit;       // load the result register and clear the set state
  } cpsl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eos;
    logic eoset;
    logic first;
    logic walk_ok;
    logic match;
    logic out_free;
  } cpsl_sts_t;

endpackage

// ===== design/common_prefix_suffix_length_core.sv =====
// Each character beat is accepted, then compared with the first string; no new beat is taken
// until the compare is done. A first string's end adds an end step; a later string's end adds
// an end step, a read and compare per suffix character matched, and a final commit step.
// At the end of a set the result is loaded into the output register, waiting while a stalled
// earlier result still holds it.
// Reset (rst_n low, synchronous) clears the set state and out_valid; stores are not reset.
module common_prefix_suffix_length_core
  import cpsl_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CH_W-1:0]  in_ch,
  input  logic             in_end_of_string,
  input  logic             in_end_of_set,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] out_prefix_len,
  output logic [LEN_W-1:0] out_suffix_len,
  output logic             out_too_long
);

  // The controller sequences each beat through accept, compare and, at a string end,
  // the backward suffix walk; the datapath owns both character stores and all counters.
  cpsl_cmd_t cmd;
  cpsl_sts_t sts;

  cpsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The result register lets the next set start streaming while a result beat waits.
  cpsl_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_ch            (in_ch),
    .in_end_of_string (in_end_of_string),
    .in_end_of_set    (in_end_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prefix_len   (out_prefix_len),
    .out_suffix_len   (out_suffix_len),
    .out_too_long     (out_too_long)
  );

endmodule

// ===== design/cpsl_ctrl.sv =====
// Controller state machine for the common prefix and suffix length block.
module cpsl_ctrl
  import cpsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cpsl_sts_t sts,
  output cpsl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_END  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.eos ? S_END : S_IDLE;
      end
      S_END: begin
        if (sts.first) begin
          cmd.end_first = 1'b1;
          state_nxt     = sts.eoset ? S_OUT : S_IDLE;
        end else begin
          cmd.end_other = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        if (sts.walk_ok) begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.eoset ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/cpsl_dp.sv =====
// Datapath for the common prefix and suffix length block: stores, counters, result register.
module cpsl_dp
  import cpsl_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cpsl_cmd_t        cmd,
  output cpsl_sts_t        sts,
  input  logic [CH_W-1:0]  in_ch,
  input  logic             in_end_of_string,
  input  logic             in_end_of_set,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] out_prefix_len,
  output logic [LEN_W-1:0] out_suffix_len,
  output logic             out_too_long
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int WW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

  logic [CH_W-1:0] first_mem [MAX_LEN];
  logic [CH_W-1:0] cur_mem   [MAX_LEN];

  logic [CW-1:0]   pos_r, flen_r, pbest_r, sbest_r, k_r, p_r;
  logic            palive_r, first_r, ovf_r;
  logic            eos_r, eoset_r, chk_r;
  logic [CH_W-1:0] ch_r, rd_first_r, rd_cur_r;
  logic            out_valid_r, out_too_long_r;
  logic [LEN_W-1:0] out_prefix_len_r, out_suffix_len_r;

  logic            room;
  logic [CW-1:0]   cur_addr, first_addr;
  logic [AW-1:0]   first_ra;
  logic [WW-1:0]   pbest_w, sbest_w;
  logic            out_free;

  assign room       = (pos_r < MAX_C);
  assign cur_addr   = pos_r - k_r - CW'(1);
  assign first_addr = flen_r - k_r - CW'(1);
  assign first_ra   = cmd.accept ? pos_r[AW-1:0] : first_addr[AW-1:0];
  assign out_free   = !out_valid_r || !out_stall;

  assign sts.eos      = eos_r;
  assign sts.eoset    = eoset_r;
  assign sts.first    = first_r;
  assign sts.walk_ok  = (k_r < sbest_r) && (k_r < pos_r) && (k_r < flen_r);
  assign sts.match    = (rd_cur_r == rd_first_r);
  assign sts.out_free = out_free;

  // Stores: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept && room && first_r) begin
      first_mem[pos_r[AW-1:0]] <= in_ch;
    end
    if (cmd.accept || cmd.walk_rd) begin
      rd_first_r <= first_mem[first_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && room && !first_r) begin
      cur_mem[pos_r[AW-1:0]] <= in_ch;
    end
    if (cmd.walk_rd) begin
      rd_cur_r <= cur_mem[cur_addr[AW-1:0]];
    end
  end

  // Beat payload, held for the compare and end-of-string steps.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r    <= in_ch;
      eos_r   <= in_end_of_string;
      eoset_r <= in_end_of_set;
      p_r     <= pos_r;
      chk_r   <= room && !first_r && palive_r && (pos_r < pbest_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      flen_r   <= '0;
      pbest_r  <= '0;
      sbest_r  <= '0;
      k_r      <= '0;
      palive_r <= 1'b1;
      first_r  <= 1'b1;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (room) begin
          pos_r <= pos_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.chk && chk_r && (ch_r != rd_first_r)) begin
        pbest_r  <= p_r;
        palive_r <= 1'b0;
      end
      if (cmd.end_first) begin
        flen_r   <= pos_r;
        pbest_r  <= pos_r;
        sbest_r  <= pos_r;
        first_r  <= 1'b0;
        pos_r    <= '0;
        palive_r <= 1'b1;
      end
      if (cmd.end_other) begin
        if (palive_r && (pos_r < pbest_r)) begin
          pbest_r <= pos_r;
        end
        k_r <= '0;
      end
      if (cmd.walk_step) begin
        k_r <= k_r + CW'(1);
      end
      if (cmd.fin) begin
        sbest_r  <= k_r;
        pos_r    <= '0;
        palive_r <= 1'b1;
      end
      if (cmd.emit) begin
        pos_r    <= '0;
        flen_r   <= '0;
        pbest_r  <= '0;
        sbest_r  <= '0;
        palive_r <= 1'b1;
        first_r  <= 1'b1;
        ovf_r    <= 1'b0;
      end
    end
  end

  // Result register; lengths saturate to the field width.
  assign pbest_w = WW'(pbest_r);
  assign sbest_w = WW'(sbest_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_prefix_len_r <= (pbest_w > WW'(FIELD_MAX)) ? FIELD_MAX : pbest_w[LEN_W-1:0];
      out_suffix_len_r <= (sbest_w > WW'(FIELD_MAX)) ? FIELD_MAX : sbest_w[LEN_W-1:0];
      out_too_long_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prefix_len = out_prefix_len_r;
  assign out_suffix_len = out_suffix_len_r;
  assign out_too_long   = out_too_long_r;

endmodule

// ===== design/cpsl_chk.sv =====
// Port-level checker for the common prefix and suffix length block, with its bind.
module cpsl_chk
  import cpsl_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [LEN_W-1:0] out_prefix_len,
  input logic [LEN_W-1:0] out_suffix_len,
  input logic             out_too_long
);

  localparam int LIM = (MAX_LEN < 2047) ? MAX_LEN : 2047;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prefix_len)
      && $stable(out_suffix_len) && $stable(out_too_long))
    else $error("result beat changed while stalled");

  // Every accepted character beat keeps the block busy for its compare cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in back-to-back cycles");

  // A result is only produced out of a busy cycle.
  a_rise_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy cycle");

  // Lengths never exceed the store depth or the field range.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_prefix_len) <= LIM) && (32'(out_suffix_len) <= LIM))
    else $error("result length out of range");

endmodule

bind common_prefix_suffix_length_core cpsl_chk #(.MAX_LEN(MAX_LEN)) u_cpsl_chk (.*);
